@@ rtl/smdsu_pkg.sv @@
// ----------------------------------------------------------------------------
// Arithmetic unit package
// Operation codes, widths and the shared request word for the arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smdsu_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;

  // Operation codes.
  localparam logic [FuncW-1:0] FuncAdd   = 3'd0;
  localparam logic [FuncW-1:0] FuncSub   = 3'd1;
  localparam logic [FuncW-1:0] FuncMul32 = 3'd2;
  localparam logic [FuncW-1:0] FuncMul64 = 3'd3;
  localparam logic [FuncW-1:0] FuncDiv32 = 3'd4;
  localparam logic [FuncW-1:0] FuncDiv64 = 3'd5;
  localparam logic [FuncW-1:0] FuncSqrt  = 3'd6;

  // Classified operation kind handed from the front end to the back end.
  typedef enum logic [2:0] {
    KindNone = 3'd0,
    KindAdd  = 3'd1,
    KindMul  = 3'd2,
    KindDiv  = 3'd3,
    KindSqrt = 3'd4
  } kind_e;

  // One classified word between the front end and the back end.
  typedef struct packed {
    kind_e             kind;
    logic              sub;
    logic [DataW-1:0]  a;
    logic [DataW-1:0]  b;
  } req_t;

  // One result word.
  typedef struct packed {
    logic [DataW-1:0] value;
    logic [DataW-1:0] rem;
    logic             dbz;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/signed_64bit_mul_div_sqrt_unit_top.sv @@
// ----------------------------------------------------------------------------
// Signed 64-bit multiply, divide and square root unit
// Queue-style front end feeding a sequential arithmetic engine.
// ----------------------------------------------------------------------------
//   Channel | Handshake      | Word
//   input   | push, full     | func_i, operand_a_i, operand_b_i
//   result  | empty, pop     | value_o, remainder_o, divide_by_zero_o
//
// Add/sub compute in one step, multiply sums three 32x32 partial products,
// divide makes one quotient bit a cycle, square root one root bit a cycle.
// The shared iterative engine sets the rate; a 4-word queue lets input keep
// flowing while it works, and a result register holds the oldest result.
// Reset clears the queue and engine state; no clearing pass is needed.
`default_nettype none

module signed_64bit_mul_div_sqrt_unit_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [smdsu_pkg::FuncW-1:0] func_i,
  input  wire logic [smdsu_pkg::DataW-1:0] operand_a_i,
  input  wire logic [smdsu_pkg::DataW-1:0] operand_b_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [smdsu_pkg::DataW-1:0]      value_o,
  output logic [smdsu_pkg::DataW-1:0]      remainder_o,
  output logic                             divide_by_zero_o
);

  smdsu_pkg::req_t req;
  smdsu_pkg::res_t res;
  logic            req_valid, req_take, res_valid;

  smdsu_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .func_i, .a_i(operand_a_i), .b_i(operand_b_i),
    .req_valid_o(req_valid), .req_take_i(req_take), .req_o(req)
  );

  smdsu_back u_back (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_take_o(req_take), .req_i(req),
    .res_valid_o(res_valid), .res_take_i(pop), .res_o(res)
  );

  assign empty            = !res_valid;
  assign value_o          = res.value;
  assign remainder_o      = res.rem;
  assign divide_by_zero_o = res.dbz;

endmodule

`default_nettype wire

@@ rtl/smdsu_front.sv @@
// ----------------------------------------------------------------------------
// Arithmetic unit front end
// Classifies each accepted word, prepares operands and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module smdsu_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic [smdsu_pkg::FuncW-1:0]   func_i,
  input  wire logic [smdsu_pkg::DataW-1:0]   a_i,
  input  wire logic [smdsu_pkg::DataW-1:0]   b_i,
  output logic                               req_valid_o,
  input  wire logic                          req_take_i,
  output smdsu_pkg::req_t                    req_o
);

  smdsu_pkg::req_t                        cls;
  smdsu_pkg::req_t                        mem_q [smdsu_pkg::QDepth];
  logic [smdsu_pkg::QPtrW-1:0]            wp_q, rp_q;
  logic [smdsu_pkg::QPtrW:0]              cnt_q;
  logic                                   wr, rd;
  logic [smdsu_pkg::DataW-1:0]            bs;

  assign bs = {{smdsu_pkg::HalfW{b_i[smdsu_pkg::HalfW-1]}}, b_i[smdsu_pkg::HalfW-1:0]};

  // Classify the operation and narrow the operands.
  always_comb begin
    cls.kind = smdsu_pkg::KindNone;
    cls.sub  = 1'b0;
    cls.a    = a_i;
    cls.b    = b_i;
    case (func_i)
      smdsu_pkg::FuncAdd: cls.kind = smdsu_pkg::KindAdd;
      smdsu_pkg::FuncSub: begin
        cls.kind = smdsu_pkg::KindAdd;
        cls.sub  = 1'b1;
      end
      smdsu_pkg::FuncMul32: begin
        cls.kind = smdsu_pkg::KindMul;
        cls.a    = {{smdsu_pkg::HalfW{a_i[smdsu_pkg::HalfW-1]}}, a_i[smdsu_pkg::HalfW-1:0]};
        cls.b    = bs;
      end
      smdsu_pkg::FuncMul64: begin
        cls.kind = smdsu_pkg::KindMul;
        cls.b    = bs;
      end
      smdsu_pkg::FuncDiv32: begin
        cls.kind = smdsu_pkg::KindDiv;
        cls.b    = bs;
        cls.sub  = 1'b1; // zero divisor returns the dividend
      end
      smdsu_pkg::FuncDiv64: cls.kind = smdsu_pkg::KindDiv;
      smdsu_pkg::FuncSqrt:  cls.kind = smdsu_pkg::KindSqrt;
      default:              cls.kind = smdsu_pkg::KindNone;
    endcase
  end

  assign full_o      = (cnt_q == smdsu_pkg::QPtrW'(0) + (smdsu_pkg::QPtrW+1)'(smdsu_pkg::QDepth));
  assign wr          = push_i && !full_o;
  assign req_valid_o = (cnt_q != '0);
  assign rd          = req_valid_o && req_take_i;
  assign req_o       = mem_q[rp_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= cls;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (smdsu_pkg::QPtrW+1)'(wr) - (smdsu_pkg::QPtrW+1)'(rd);
    end
  end

endmodule

`default_nettype wire

@@ rtl/smdsu_back.sv @@
// ----------------------------------------------------------------------------
// Arithmetic unit back end
// Sequential engine: add in one step, multiply by 32-bit partial products,
// divide and square root one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smdsu_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  output logic                    req_take_o,
  input  wire smdsu_pkg::req_t    req_i,
  output logic                    res_valid_o,
  input  wire logic               res_take_i,
  output smdsu_pkg::res_t         res_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StIter = 4'b0100,
    StDone = 4'b1000
  } state_e;

  localparam int unsigned DW = smdsu_pkg::DataW;
  localparam int unsigned HW = smdsu_pkg::HalfW;

  state_e              st_q, st_d;
  smdsu_pkg::kind_e    kind_q;
  logic [DW-1:0]       x_q, y_q, acc_q, rem_q;
  logic [DW:0]         rt_q;
  logic [6:0]          cnt_q;
  logic                nq_q, nr_q;
  logic [1:0]          mstep_q;
  smdsu_pkg::res_t     out_q;
  logic                out_v_q;
  logic [2*HW-1:0]     pp;
  logic [DW:0]         trial;
  logic [DW+1:0]       strial;
  logic [DW-1:0]       ma, mb;
  logic                fin;

  assign ma = req_i.a[DW-1] ? (DW'(0) - req_i.a) : req_i.a;
  assign mb = req_i.b[DW-1] ? (DW'(0) - req_i.b) : req_i.b;

  // Accept a new word when idle and the output slot will be free.
  assign req_take_o  = (st_q == StIdle) && req_valid_i && (!out_v_q || res_take_i);
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  // Unsigned 32x32 partial product for the multiply sequence.
  always_comb begin
    case (mstep_q)
      2'd0:    pp = x_q[HW-1:0] * y_q[HW-1:0];
      2'd1:    pp = x_q[DW-1:HW] * y_q[HW-1:0];
      default: pp = x_q[HW-1:0] * y_q[DW-1:HW];
    endcase
  end

  // Restoring divide step and square root step.
  assign trial  = {rem_q, acc_q[DW-1]} ;
  assign strial = {rem_q, acc_q[DW-1:DW-2]} - {rt_q[DW-1:0], 2'b01};
  assign fin    = (cnt_q == 7'd1);

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (req_take_o) begin
        case (req_i.kind)
          smdsu_pkg::KindMul:  st_d = StMul;
          smdsu_pkg::KindDiv:  st_d = (req_i.b == '0) ? StDone : StIter;
          smdsu_pkg::KindSqrt: st_d = req_i.a[DW-1] ? StDone : StIter;
          default:             st_d = StDone;
        endcase
      end
      StMul:   if (mstep_q == 2'd2) st_d = StDone;
      StIter:  if (fin) st_d = StDone;
      StDone:  if (!out_v_q || res_take_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StDone && (!out_v_q || res_take_i)) out_v_q <= 1'b1;
      else if (res_take_i) out_v_q <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: if (req_take_o) begin
        mstep_q <= 2'd0;
        cnt_q   <= (req_i.kind == smdsu_pkg::KindSqrt) ? 7'(DW/2) : 7'(DW);
        rem_q   <= '0;
        rt_q    <= '0;
        nr_q    <= req_i.a[DW-1];
        x_q     <= req_i.a;
        y_q     <= (req_i.kind == smdsu_pkg::KindDiv) ? mb : req_i.b;
        case (req_i.kind)
          smdsu_pkg::KindAdd: acc_q <= req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);
          smdsu_pkg::KindMul: acc_q <= '0;
          smdsu_pkg::KindDiv: acc_q <= (req_i.b == '0) ? (req_i.sub ? req_i.a : '0) : ma;
          smdsu_pkg::KindSqrt: acc_q <= req_i.a[DW-1] ? '0 : req_i.a;
          default: acc_q <= '0;
        endcase
        // A zero divisor finishes at once and raises the flag.
        if (req_i.kind == smdsu_pkg::KindDiv && req_i.b == '0) begin
          kind_q <= smdsu_pkg::KindNone;
          nq_q   <= 1'b1;
        end else begin
          kind_q <= req_i.kind;
          nq_q   <= (req_i.kind == smdsu_pkg::KindNone) ? 1'b0 :
                    (req_i.a[DW-1] ^ req_i.b[DW-1]);
        end
      end
      StMul: begin
        mstep_q <= mstep_q + 2'd1;
        if (mstep_q == 2'd0) acc_q <= acc_q + pp;
        else acc_q <= acc_q + {pp[HW-1:0], {HW{1'b0}}};
      end
      StIter: begin
        cnt_q <= cnt_q - 7'd1;
        if (kind_q == smdsu_pkg::KindDiv) begin
          if (trial >= {1'b0, y_q}) begin
            rem_q <= DW'(trial - {1'b0, y_q});
            acc_q <= {acc_q[DW-2:0], 1'b1};
          end else begin
            rem_q <= trial[DW-1:0];
            acc_q <= {acc_q[DW-2:0], 1'b0};
          end
        end else begin
          acc_q <= {acc_q[DW-3:0], 2'b00};
          if (!strial[DW+1]) begin
            rem_q <= strial[DW-1:0];
            rt_q  <= {rt_q[DW-1:0], 1'b1};
          end else begin
            rem_q <= {rem_q[DW-3:0], acc_q[DW-1:DW-2]};
            rt_q  <= {rt_q[DW-1:0], 1'b0};
          end
        end
      end
      StDone: if (!out_v_q || res_take_i) begin
        out_q.rem <= '0;
        out_q.dbz <= 1'b0;
        case (kind_q)
          smdsu_pkg::KindDiv: begin
            out_q.value <= nq_q ? (DW'(0) - acc_q) : acc_q;
            out_q.rem   <= nr_q ? (DW'(0) - rem_q) : rem_q;
          end
          smdsu_pkg::KindSqrt: out_q.value <= rt_q[DW-1:0];
          smdsu_pkg::KindNone: begin
            out_q.value <= acc_q;
            out_q.dbz   <= nq_q;
          end
          default: out_q.value <= acc_q;
        endcase
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
